### sv/mtw_pkg.sv
// Shared types and constants for the match timer with wrap extension.
package mtw_pkg;

  // Operation carried by one input transaction.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // Register map; indices below REG_COUNT address the match registers.
  localparam logic [3:0] REG_COUNT  = 4'd4;
  localparam logic [3:0] REG_STATUS = 4'd5;
  localparam logic [3:0] REG_ENABLE = 4'd7;
  localparam logic [3:0] REG_HIGH   = 4'd8;

  // Number of match registers reachable through the register map.
  localparam int MAX_ADDR_MATCH = 4;

  localparam int DATA_W = 32;
  localparam int IRQ_W  = 4;

  // One result transaction.
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [IRQ_W-1:0]  irq_lines;
  } result_t;

endpackage

### sv/mtw_core.sv
// Timer register file: counter, high word, match compare, status and enable.
module mtw_core #(
  parameter int NUM_MATCH   = 4,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic [1:0]                   op,
  input  logic [3:0]                   reg_index,
  input  logic [mtw_pkg::DATA_W-1:0]   write_data,
  output mtw_pkg::result_t             result
);

  localparam int NumAddr = (NUM_MATCH < mtw_pkg::MAX_ADDR_MATCH) ?
                           NUM_MATCH : mtw_pkg::MAX_ADDR_MATCH;
  localparam logic [mtw_pkg::IRQ_W-1:0] BitMask = mtw_pkg::IRQ_W'((1 << NumAddr) - 1);

  logic [COUNT_WIDTH-1:0]      count_low, count_low_next;
  logic [COUNT_WIDTH-1:0]      tick_count;
  logic [mtw_pkg::DATA_W-1:0]  count_high, count_high_next;
  logic [mtw_pkg::DATA_W-1:0]  high_snapshot, high_snapshot_next;
  logic [COUNT_WIDTH-1:0]      match_values [NumAddr];
  logic [COUNT_WIDTH-1:0]      match_values_next [NumAddr];
  logic [mtw_pkg::IRQ_W-1:0]   match_status, match_status_next;
  logic [mtw_pkg::IRQ_W-1:0]   irq_enable_mask, irq_enable_mask_next;
  logic [mtw_pkg::DATA_W-1:0]  rd;

  assign tick_count = count_low + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

  always_comb begin
    count_low_next       = count_low;
    count_high_next      = count_high;
    high_snapshot_next   = high_snapshot;
    match_values_next    = match_values;
    match_status_next    = match_status;
    irq_enable_mask_next = irq_enable_mask;
    rd                   = '0;
    unique case (mtw_pkg::op_t'(op))
      mtw_pkg::OP_TICK: begin
        count_low_next = tick_count;
        if (tick_count == '0) begin
          count_high_next = count_high + 32'd1;
        end
        for (int i = 0; i < NumAddr; i++) begin
          if (match_values[i] == tick_count) begin
            match_status_next[i] = 1'b1;
          end
        end
      end
      mtw_pkg::OP_READ: begin
        for (int i = 0; i < NumAddr; i++) begin
          if (reg_index == 4'(i)) begin
            rd = mtw_pkg::DATA_W'(match_values[i]);
          end
        end
        if (reg_index == mtw_pkg::REG_COUNT) begin
          // low-word read latches the high word for a coherent 64-bit view
          high_snapshot_next = count_high;
          rd = mtw_pkg::DATA_W'(count_low);
        end else if (reg_index == mtw_pkg::REG_STATUS) begin
          rd = mtw_pkg::DATA_W'(match_status);
        end else if (reg_index == mtw_pkg::REG_ENABLE) begin
          rd = mtw_pkg::DATA_W'(irq_enable_mask);
        end else if (reg_index == mtw_pkg::REG_HIGH) begin
          rd = high_snapshot;
        end
      end
      mtw_pkg::OP_WRITE: begin
        for (int i = 0; i < NumAddr; i++) begin
          if (reg_index == 4'(i)) begin
            match_values_next[i] = write_data[COUNT_WIDTH-1:0];
          end
        end
        if (reg_index == mtw_pkg::REG_COUNT) begin
          count_low_next = write_data[COUNT_WIDTH-1:0];
        end else if (reg_index == mtw_pkg::REG_STATUS) begin
          // write one to clear
          match_status_next = match_status & ~write_data[mtw_pkg::IRQ_W-1:0] & BitMask;
        end else if (reg_index == mtw_pkg::REG_ENABLE) begin
          irq_enable_mask_next = write_data[mtw_pkg::IRQ_W-1:0] & BitMask;
        end
      end
      mtw_pkg::OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  assign result.read_data = rd;
  assign result.irq_lines = match_status_next & irq_enable_mask_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_low       <= '0;
      count_high      <= '0;
      high_snapshot   <= '0;
      match_status    <= '0;
      irq_enable_mask <= '0;
      for (int i = 0; i < NumAddr; i++) begin
        match_values[i] <= '0;
      end
    end else if (fire) begin
      count_low       <= count_low_next;
      count_high      <= count_high_next;
      high_snapshot   <= high_snapshot_next;
      match_status    <= match_status_next;
      irq_enable_mask <= irq_enable_mask_next;
      match_values    <= match_values_next;
    end
  end

endmodule

### sv/mtw_out_buf.sv
// Two-entry result buffer: output register plus skid register.
module mtw_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mtw_pkg::result_t  push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output mtw_pkg::result_t  out_data
);

  logic             skid_valid;
  mtw_pkg::result_t skid_data;
  logic             pop;

  assign full = skid_valid;
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid) begin
      out_valid <= push;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || (pop && !skid_valid)) begin
      out_data <= push_data;
    end else if (pop) begin
      out_data <= skid_data;
    end
    if (out_valid && !pop && push) begin
      skid_data <= push_data;
    end
  end

endmodule

### sv/match_timer_with_wrap_extension_top.sv
// Top level of the free-running match timer with wrap-extended high word.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid/in_stall, op, reg_index,| into block
//           | write_data                       |
//   out     | out_valid/out_stall, read_data,  | out of block
//           | irq_lines                        |
//
// Each input transaction (tick, read or write) is applied to the register
// file in the cycle it is accepted; its result is registered on the same
// edge, in output or skid register. One transaction per clock unless stalled.
// A two-entry output buffer (output register plus skid) keeps intake going
// while one result waits; in_stall rises only when both entries are full.
// Reset (rst, synchronous) clears counter, high word, snapshot, match
// values, status and enable mask, and empties the output buffer.
module match_timer_with_wrap_extension_top #(
  parameter int NUM_MATCH   = 4,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        op,
  input  logic [3:0]                        reg_index,
  input  logic [mtw_pkg::DATA_W-1:0]        write_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mtw_pkg::DATA_W-1:0]        read_data,
  output logic [mtw_pkg::IRQ_W-1:0]         irq_lines
);

  logic             accept;
  mtw_pkg::result_t core_result;
  mtw_pkg::result_t out_data;

  // A transaction is taken whenever the skid entry is free.
  assign accept = in_valid && !in_stall;

  mtw_core #(
    .NUM_MATCH   (NUM_MATCH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (accept),
    .op         (op),
    .reg_index  (reg_index),
    .write_data (write_data),
    .result     (core_result)
  );

  // Results queue here so the output side can stall without losing one.
  mtw_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (core_result),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign read_data = out_data.read_data;
  assign irq_lines = out_data.irq_lines;

  // Stall only when a result is already presented.
  a_stall_needs_output: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("in_stall high with no result presented");

  // Every accepted transaction shows up on the output side.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  // Accepting behind a stalled result fills the skid entry.
  a_skid_fills: assert property (@(posedge clk) disable iff (rst)
    (accept && out_valid && out_stall) |=> in_stall)
    else $error("second queued result did not occupy the skid entry");

endmodule

### sim/match_timer_with_wrap_extension_top_tb.sv
// Self-checking testbench for the match timer with wrap-extended high word.
module match_timer_with_wrap_extension_top_tb;

  // Block configuration under test (defaults of the top level).
  localparam int N_MATCH = 4;
  localparam int CNT_W   = 32;
  localparam int ADDR_M  = (N_MATCH < mtw_pkg::MAX_ADDR_MATCH) ? N_MATCH
                                                               : mtw_pkg::MAX_ADDR_MATCH;
  localparam logic [31:0] CNT_MASK =
    (CNT_W >= 32) ? 32'hFFFF_FFFF : ((32'd1 << CNT_W) - 32'd1);
  localparam logic [3:0] BIT_MASK = 4'(((1 << N_MATCH) - 1) & 15);

  // Random part stops after this many input transactions in total.
  localparam int TOTAL_ITEMS = 550;
  // Cycles without any accepted transaction before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Length of the forced receiver hold-off, in cycles.
  localparam int HOLD_CYCLES = 40;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  logic [1:0]                  op;
  logic [3:0]                  reg_index;
  logic [mtw_pkg::DATA_W-1:0]  write_data;
  logic                        out_valid;
  logic                        out_stall;
  logic [mtw_pkg::DATA_W-1:0]  read_data;
  logic [mtw_pkg::IRQ_W-1:0]   irq_lines;

  // Shared stimulus controls: burst turns off idling on both sides,
  // hold_req asks the receiver process for one long hold-off.
  bit burst;
  bit hold_req;
  bit hold_done;
  int sent;
  int in_backpressure;

  match_timer_with_wrap_extension_top #(
    .NUM_MATCH  (N_MATCH),
    .COUNT_WIDTH(CNT_W)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .reg_index (reg_index),
    .write_data(write_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_data (read_data),
    .irq_lines (irq_lines)
  );

  // Timer register-file predictor plus queue of expected result transactions.
  class timer_scoreboard;
    logic [31:0]      cnt_lo;
    logic [31:0]      cnt_hi;
    logic [31:0]      hi_latch;
    logic [31:0]      match_regs [N_MATCH];
    logic [3:0]       status;
    logic [3:0]       enable;
    mtw_pkg::result_t expected_results [$];
    int               errors;
    int               checked;
    int               ticks;
    int               wraps;
    int               match_hits;
    int               reads;
    int               writes;

    function new();
      cnt_lo   = '0;
      cnt_hi   = '0;
      hi_latch = '0;
      foreach (match_regs[i]) match_regs[i] = '0;
      status   = '0;
      enable   = '0;
      errors   = 0;
      checked  = 0;
      ticks    = 0;
      wraps    = 0;
      match_hits = 0;
      reads    = 0;
      writes   = 0;
    endfunction

    // Apply one accepted input transaction and queue the result it causes.
    function void note_transaction(logic [1:0] op_in, logic [3:0] idx, logic [31:0] data);
      logic [31:0]      rd;
      logic [31:0]      nxt;
      mtw_pkg::result_t res;
      rd = '0;
      case (mtw_pkg::op_t'(op_in))
        mtw_pkg::OP_TICK: begin
          ticks++;
          nxt = (cnt_lo + 32'd1) & CNT_MASK;
          if (nxt == '0) begin
            cnt_hi = cnt_hi + 32'd1;
            wraps++;
          end
          cnt_lo = nxt;
          for (int i = 0; i < ADDR_M; i++) begin
            if (match_regs[i] == cnt_lo) begin
              status[i] = 1'b1;
              match_hits++;
            end
          end
          status &= BIT_MASK;
        end
        mtw_pkg::OP_READ: begin
          reads++;
          if (idx < ADDR_M) begin
            rd = match_regs[idx];
          end else begin
            case (idx)
              mtw_pkg::REG_COUNT: begin
                hi_latch = cnt_hi;
                rd = cnt_lo;
              end
              mtw_pkg::REG_STATUS: rd = {28'd0, status};
              mtw_pkg::REG_ENABLE: rd = {28'd0, enable};
              mtw_pkg::REG_HIGH:   rd = hi_latch;
              default:             rd = '0;
            endcase
          end
        end
        mtw_pkg::OP_WRITE: begin
          writes++;
          if (idx < ADDR_M) begin
            match_regs[idx] = data & CNT_MASK;
          end else begin
            case (idx)
              mtw_pkg::REG_COUNT:  cnt_lo = data & CNT_MASK;
              mtw_pkg::REG_STATUS: status &= ~data[3:0] & BIT_MASK;
              mtw_pkg::REG_ENABLE: enable = data[3:0] & BIT_MASK;
              default: ;
            endcase
          end
        end
        default: ;
      endcase
      res.read_data = rd;
      res.irq_lines = status & enable;
      expected_results.push_back(res);
    endfunction

    // Compare one accepted result transaction with the oldest expectation.
    function void check_result(logic [31:0] rd, logic [3:0] irq);
      mtw_pkg::result_t exp_res;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result read_data=%h irq_lines=%h", $time, rd, irq);
        errors++;
        return;
      end
      exp_res = expected_results.pop_front();
      checked++;
      if (rd !== exp_res.read_data) begin
        $display("%0t: read_data expected %h actual %h", $time, exp_res.read_data, rd);
        errors++;
      end
      if (irq !== exp_res.irq_lines) begin
        $display("%0t: irq_lines expected %h actual %h", $time, exp_res.irq_lines, irq);
        errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  timer_scoreboard sb;

  // Free-running clock, period 4.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Monitor and watchdog. Everything here is sampled at the rising edge, so
  // the values seen are the ones that were set up before that edge.
  int idle_cycles;
  always @(posedge clk) begin
    bit any_accept;
    any_accept = 1'b0;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (in_valid && !in_stall) begin
        sb.note_transaction(op, reg_index, write_data);
        any_accept = 1'b1;
      end
      if (in_valid && in_stall) in_backpressure++;
      if (out_valid && !out_stall) begin
        sb.check_result(read_data, irq_lines);
        any_accept = 1'b1;
      end
      idle_cycles = any_accept ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("match_timer_with_wrap_extension_top: mismatch");
        $finish;
      end
    end
  end

  // Receiver: random stall about 20% of cycles, none during bursts, and one
  // long hold-off on request so the block's output buffer fills up.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (burst) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 20);
      end
    end
  end

  // Offer one input transaction, possibly after a short gap, and return at
  // the edge where it is accepted. in_valid is left high for the next call.
  task automatic send(mtw_pkg::op_t o, logic [3:0] idx, logic [31:0] data);
    if (!burst && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= o;
    reg_index  <= idx;
    write_data <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Main stimulus.
  initial begin
    logic [31:0] base;
    int          k;
    int          m;
    sb         = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    op         = mtw_pkg::OP_TICK;
    reg_index  = '0;
    write_data = '0;
    burst      = 1'b0;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    sent       = 0;
    in_backpressure = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: enable all lines with an all-ones word, arm every match.
    send(mtw_pkg::OP_WRITE, mtw_pkg::REG_ENABLE, 32'hFFFF_FFFF);
    send(mtw_pkg::OP_WRITE, 4'd0, 32'd3);
    send(mtw_pkg::OP_WRITE, 4'd1, 32'hFFFF_FFFF);
    send(mtw_pkg::OP_WRITE, 4'd2, 32'd0);
    send(mtw_pkg::OP_WRITE, 4'd3, 32'd1);
    // Matches fire on count 1 and 3.
    repeat (3) send(mtw_pkg::OP_TICK, 4'd0, 32'd0);
    send(mtw_pkg::OP_READ, mtw_pkg::REG_STATUS, 32'd0);
    // Write-one-to-clear of a single bit.
    send(mtw_pkg::OP_WRITE, mtw_pkg::REG_STATUS, 32'd1);
    // Counter load near the top: match at all ones, then wrap onto zero,
    // which bumps the high word and hits the match at zero.
    send(mtw_pkg::OP_WRITE, mtw_pkg::REG_COUNT, 32'hFFFF_FFFE);
    send(mtw_pkg::OP_TICK, 4'd15, 32'hFFFF_FFFF);
    send(mtw_pkg::OP_TICK, 4'd4, 32'd0);
    // Low read latches the high word; high read returns the latched copy.
    send(mtw_pkg::OP_READ, mtw_pkg::REG_COUNT, 32'd0);
    send(mtw_pkg::OP_READ, mtw_pkg::REG_HIGH, 32'd0);
    // Latched high word is read-only.
    send(mtw_pkg::OP_WRITE, mtw_pkg::REG_HIGH, 32'hFFFF_FFFF);
    send(mtw_pkg::OP_READ, mtw_pkg::REG_HIGH, 32'd0);
    // Unused and unmapped indices: reads give zero, writes are dropped.
    send(mtw_pkg::OP_WRITE, 4'd6, 32'hFFFF_FFFF);
    send(mtw_pkg::OP_READ, 4'd6, 32'd0);
    send(mtw_pkg::OP_WRITE, 4'd15, 32'hFFFF_FFFF);
    send(mtw_pkg::OP_READ, 4'd15, 32'd0);
    // Op code three does nothing.
    send(mtw_pkg::OP_NOP, mtw_pkg::REG_COUNT, 32'hFFFF_FFFF);
    // Writing a match equal to the current count must not set status.
    send(mtw_pkg::OP_WRITE, mtw_pkg::REG_STATUS, 32'hFFFF_FFFF);
    send(mtw_pkg::OP_WRITE, 4'd2, 32'd0);
    send(mtw_pkg::OP_READ, mtw_pkg::REG_STATUS, 32'd0);
    send(mtw_pkg::OP_WRITE, mtw_pkg::REG_ENABLE, 32'd0);

    // Random part: mostly load-arm-tick-check sequences, the rest noise.
    while (sent < TOTAL_ITEMS) begin
      // No idling at all on either side for one stretch.
      burst = (sent >= 150 && sent < 260);
      // Once, stop the receiver for a long stretch and keep offering.
      if (sent >= 330 && !hold_done) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
        burst     = 1'b1;
        repeat (12) send(mtw_pkg::OP_TICK, 4'($urandom_range(0, 15)), $urandom());
        burst = 1'b0;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          // Load the counter, arm a match k ticks ahead, tick up to it.
          base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                             : $urandom();
          k = $urandom_range(1, 4);
          m = $urandom_range(0, 3);
          send(mtw_pkg::OP_WRITE, mtw_pkg::REG_COUNT, base);
          send(mtw_pkg::OP_WRITE, 4'(m), base + 32'(k));
          if ($urandom_range(0, 1)) send(mtw_pkg::OP_WRITE, mtw_pkg::REG_ENABLE, $urandom());
          repeat (k + $urandom_range(0, 1))
            send(mtw_pkg::OP_TICK, 4'($urandom_range(0, 15)), $urandom());
          send(mtw_pkg::OP_READ, mtw_pkg::REG_STATUS, $urandom());
          if ($urandom_range(0, 1)) begin
            send(mtw_pkg::OP_READ, mtw_pkg::REG_COUNT, $urandom());
            send(mtw_pkg::OP_READ, mtw_pkg::REG_HIGH, $urandom());
          end
          if ($urandom_range(0, 1)) send(mtw_pkg::OP_WRITE, mtw_pkg::REG_STATUS, $urandom());
        end
        5: begin
          // Enable mask update and readback.
          send(mtw_pkg::OP_WRITE, mtw_pkg::REG_ENABLE, $urandom());
          send(mtw_pkg::OP_READ, mtw_pkg::REG_ENABLE, $urandom());
        end
        default: begin
          // Noise: any op, any index, any data.
          send(mtw_pkg::op_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), $urandom());
        end
      endcase
    end
    in_valid <= 1'b0;

    // Drain, then keep clocking so that any stray result is still caught.
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d transactions: %0d ticks, %0d reads, %0d writes, %0d results checked",
             sent, sb.ticks, sb.reads, sb.writes, sb.checked);
    $display("Counter wraps %0d, match hits %0d, input stall cycles %0d",
             sb.wraps, sb.match_hits, in_backpressure);
    if (sb.errors == 0) begin
      $display("match_timer_with_wrap_extension_top: match");
    end else begin
      $display("match_timer_with_wrap_extension_top: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
sv/mtw_pkg.sv
sv/mtw_core.sv
sv/mtw_out_buf.sv
sv/match_timer_with_wrap_extension_top.sv
sim/match_timer_with_wrap_extension_top_tb.sv
